[hw/rtl/fpl2_pkg.sv]
// Shared constants and types for the fixed-point log2 core.
// No dependencies.
package fpl2_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_W         = 4;
  localparam int LOG_W          = 16;
  localparam int X_W            = 16;
  localparam logic [FRAC_W-1:0] FRAC_RESET = 4'd12;

  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;

endpackage

[hw/rtl/fixed_point_log2_core.sv]
// Top level of the fixed-point log2 core: config register, normalizer,
// chain of squaring cells, result assembly. Depends on fpl2_pkg, fpl2_norm, fpl2_cell.
//
// Computes log2 of an unsigned fixed-point operand with frac_bits fraction bits
// (clamped to 1..DATA_WIDTH-2) by normalizing into [1,2) and then squaring once
// per fraction bit. The squarings run in a fixed row of DATA_WIDTH-2 cells, one
// multiplier each, and a new transaction is taken every cycle unless the output stalls.
// A stalled output holds the whole row. A zero operand yields zero; tuser flags
// results whose exact value does not fit the signed DATA_WIDTH range.
module fixed_point_log2_core #(
  parameter int DATA_WIDTH = fpl2_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fpl2_pkg::FRAC_W-1:0]   cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [fpl2_pkg::X_W-1:0]      s_axis_tdata,   // [15:0] x_value
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [fpl2_pkg::LOG_W-1:0]    m_axis_tdata,   // [15:0] log_value
  output logic                          m_axis_tuser    // [0] wrapped
);

  localparam int RW    = $clog2(DATA_WIDTH);
  localparam int IW    = RW + 1;
  localparam int FW    = DATA_WIDTH - 2;
  localparam int CELLS = DATA_WIDTH - 2;
  localparam int YW    = DATA_WIDTH + IW;
  localparam int CW    = RW + fpl2_pkg::FRAC_W;
  localparam int LW    = fpl2_pkg::LOG_W;
  localparam int XW    = fpl2_pkg::X_W;

  logic [fpl2_pkg::FRAC_W-1:0] frac_bits;
  logic [CW-1:0]               f_ext;
  logic [RW-1:0]               r;
  logic                        en;
  logic [DATA_WIDTH+XW-1:0]    x_ext;
  logic [DATA_WIDTH-1:0]       x_in;

  fpl2_pkg::ctl_t              ctl  [CELLS+1];
  logic [DATA_WIDTH-1:0]       m    [CELLS+1];
  logic signed [IW-1:0]        ip   [CELLS+1];
  logic [FW-1:0]               frac [CELLS+1];

  logic [YW-1:0]               y;
  logic [YW-DATA_WIDTH:0]      y_hi;
  logic [LW+DATA_WIDTH-1:0]    y_ext;
  logic                        wrap_next;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      frac_bits <= fpl2_pkg::FRAC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frac_bits <= cfg_data;
    end
  end

  always_comb begin
    f_ext = CW'(frac_bits);
    if (f_ext == '0) begin
      r = RW'(1);
    end else if (f_ext > CW'(DATA_WIDTH - 2)) begin
      r = RW'(DATA_WIDTH - 2);
    end else begin
      r = f_ext[RW-1:0];
    end
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !rst;
  assign x_ext         = {{DATA_WIDTH{1'b0}}, s_axis_tdata};
  assign x_in          = x_ext[DATA_WIDTH-1:0];

  fpl2_norm #(
    .DATA_WIDTH(DATA_WIDTH), .RW(RW), .IW(IW), .FW(FW)
  ) u_norm (
    .clk(clk), .rst(rst), .en(en), .r(r),
    .in_valid(s_axis_tvalid),
    .in_x(x_in),
    .out_ctl(ctl[0]), .out_m(m[0]), .out_ip(ip[0]), .out_frac(frac[0])
  );

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    fpl2_cell #(
      .DATA_WIDTH(DATA_WIDTH), .RW(RW), .IW(IW), .FW(FW), .K(k)
    ) u_cell (
      .clk(clk), .rst(rst), .en(en), .r(r),
      .in_ctl(ctl[k]), .in_m(m[k]), .in_ip(ip[k]), .in_frac(frac[k]),
      .out_ctl(ctl[k+1]), .out_m(m[k+1]), .out_ip(ip[k+1]), .out_frac(frac[k+1])
    );
  end

  always_comb begin
    if (ctl[CELLS].zero) begin
      y = '0;
    end else begin
      y = ({{(YW-IW){ip[CELLS][IW-1]}}, ip[CELLS]} << r) + YW'(frac[CELLS]);
    end
    y_hi      = y[YW-1:DATA_WIDTH-1];
    wrap_next = !(&y_hi) && (|y_hi);
    y_ext     = {{LW{1'b0}}, y[DATA_WIDTH-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= ctl[CELLS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= y_ext[LW-1:0];
      m_axis_tuser <= wrap_next;
    end
  end

endmodule

[hw/rtl/fpl2_norm.sv]
// Normalization front end: leading-one search, then shift into [1,2).
// Depends on fpl2_pkg.
module fpl2_norm #(
  parameter int DATA_WIDTH = fpl2_pkg::DATA_WIDTH_DEF,
  parameter int RW = $clog2(DATA_WIDTH),
  parameter int IW = RW + 1,
  parameter int FW = DATA_WIDTH - 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic [RW-1:0]          r,
  input  logic                   in_valid,
  input  logic [DATA_WIDTH-1:0]  in_x,
  output fpl2_pkg::ctl_t         out_ctl,
  output logic [DATA_WIDTH-1:0]  out_m,
  output logic signed [IW-1:0]   out_ip,
  output logic [FW-1:0]          out_frac
);

  logic [RW-1:0]         lead;
  fpl2_pkg::ctl_t        ctl_a;
  logic [DATA_WIDTH-1:0] x_a;
  logic [RW-1:0]         p_a;
  logic [RW-1:0]         sh;
  logic [DATA_WIDTH-1:0] m_next;
  logic signed [IW-1:0]  ip_next;

  always_comb begin
    lead = '0;
    for (int i = 0; i < DATA_WIDTH; i++) begin
      if (in_x[i]) lead = RW'(i);
    end
  end

  always_comb begin
    ip_next = $signed({1'b0, p_a}) - $signed({1'b0, r});
    if (p_a >= r) begin
      sh     = p_a - r;
      m_next = x_a >> sh;
    end else begin
      sh     = r - p_a;
      m_next = x_a << sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a   <= '0;
      out_ctl <= '0;
    end else if (en) begin
      ctl_a.valid <= in_valid;
      ctl_a.zero  <= (in_x == '0);
      out_ctl     <= ctl_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_a      <= in_x;
      p_a      <= lead;
      out_m    <= m_next;
      out_ip   <= ip_next;
      out_frac <= '0;
    end
  end

endmodule

[hw/rtl/fpl2_cell.sv]
// One squaring cell: produces one fraction bit when its index is below r.
// Depends on fpl2_pkg.
module fpl2_cell #(
  parameter int DATA_WIDTH = fpl2_pkg::DATA_WIDTH_DEF,
  parameter int RW = $clog2(DATA_WIDTH),
  parameter int IW = RW + 1,
  parameter int FW = DATA_WIDTH - 2,
  parameter int K = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic [RW-1:0]          r,
  input  fpl2_pkg::ctl_t         in_ctl,
  input  logic [DATA_WIDTH-1:0]  in_m,
  input  logic signed [IW-1:0]   in_ip,
  input  logic [FW-1:0]          in_frac,
  output fpl2_pkg::ctl_t         out_ctl,
  output logic [DATA_WIDTH-1:0]  out_m,
  output logic signed [IW-1:0]   out_ip,
  output logic [FW-1:0]          out_frac
);

  logic [2*DATA_WIDTH-1:0] prod;
  logic [2*DATA_WIDTH-1:0] prod_sh;
  logic [DATA_WIDTH-1:0]   sq;
  logic [DATA_WIDTH:0]     two;
  logic                    ge;
  logic                    active;
  logic [DATA_WIDTH-1:0]   m_next;
  logic [FW-1:0]           frac_next;

  always_comb begin
    prod    = in_m * in_m;
    prod_sh = prod >> r;
    sq      = prod_sh[DATA_WIDTH-1:0];
    two     = (DATA_WIDTH+1)'(1) << (r + 1'b1);
    ge      = ({1'b0, sq} >= two);
    active  = (RW'(K) < r);
    if (active) begin
      m_next    = ge ? (sq >> 1) : sq;
      frac_next = {in_frac[FW-2:0], ge};
    end else begin
      m_next    = in_m;
      frac_next = in_frac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (en) begin
      out_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_m    <= m_next;
      out_ip   <= in_ip;
      out_frac <= frac_next;
    end
  end

endmodule

[dv/fixed_point_log2_core_test.sv]
// Self-checking testbench for fixed_point_log2_core: directed and random operands
// over many frac_bits settings, checked against an in-bench log2 predictor.
// Depends on fpl2_pkg and fixed_point_log2_core.
module fixed_point_log2_core_test;
  import fpl2_pkg::*;

  localparam int DATA_WIDTH  = DATA_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LATENCY     = DATA_WIDTH + 1;

  typedef struct packed {
    logic [LOG_W-1:0] log_value;
    logic             wrapped;
  } log_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [FRAC_W-1:0] cfg_data = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [X_W-1:0]    s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [LOG_W-1:0]  m_axis_tdata;
  logic              m_axis_tuser;

  log_result_t       log_expect_q[$];
  logic [FRAC_W-1:0] frac_setting = FRAC_RESET;
  int                fail_count = 0;
  int                cycle_count = 0;
  int                src_idle_pct = 0;
  int                sink_idle_pct = 0;
  int                sink_hold_cycles = 0;

  fixed_point_log2_core #(.DATA_WIDTH(DATA_WIDTH)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [15:0] x_value
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [15:0] log_value
    .m_axis_tuser  (m_axis_tuser)    // [0] wrapped
  );

  always #5 clk = ~clk;

  function automatic int unsigned clamp_frac(input logic [FRAC_W-1:0] frac_reg);
    int unsigned r;
    r = frac_reg;
    if (r < 1) r = 1;
    if (r > DATA_WIDTH - 2) r = DATA_WIDTH - 2;
    return r;
  endfunction

  // normalize into [1,2), then one squaring per fraction bit
  function automatic log_result_t predict_log2(input logic [X_W-1:0] x_in,
                                               input logic [FRAC_W-1:0] frac_reg);
    int unsigned r;
    int          n;
    longint      mant;
    longint      unit;
    longint      y;
    longint      weight;
    longint      dw_mask;
    log_result_t res;
    r = clamp_frac(frac_reg);
    unit = 64'sd1 <<< r;
    dw_mask = (64'sd1 <<< DATA_WIDTH) - 1;
    mant = longint'(x_in) & dw_mask;
    y = 0;
    if (mant != 0) begin
      weight = 64'sd1 <<< (r - 1);
      while (mant < unit) begin
        mant = mant <<< 1;
        y = y - unit;
      end
      while (mant >= 2 * unit) begin
        mant = mant >>> 1;
        y = y + unit;
      end
      for (n = 0; n < r; n++) begin
        mant = ((mant * mant) >>> r) & dw_mask;
        if (mant >= 2 * unit) begin
          mant = mant >>> 1;
          y = y + weight;
        end
        weight = weight >>> 1;
      end
    end
    res.log_value = y[LOG_W-1:0];
    res.wrapped = (y < -(64'sd1 <<< (DATA_WIDTH - 1))) ||
                  (y > (64'sd1 <<< (DATA_WIDTH - 1)) - 1);
    return res;
  endfunction

  function automatic logic [X_W-1:0] pick_operand(input logic [FRAC_W-1:0] frac_reg);
    int unsigned r;
    int          near;
    r = clamp_frac(frac_reg);
    case ($urandom_range(9))
      0: return X_W'($urandom_range(7));
      1: return X_W'(1) << $urandom_range(X_W - 1);
      2: begin
        near = (1 << r) + $urandom_range(16) - 8;
        return X_W'(near);
      end
      3: return {X_W{1'b1}} - X_W'($urandom_range(7));
      default: return X_W'($urandom_range(2 ** X_W - 1));
    endcase
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls, plus a counted hold-off
  always @(negedge clk) begin
    if (sink_hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold_cycles--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    log_result_t want;
    if (rst) begin
      frac_setting = FRAC_RESET;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (log_expect_q.size() == 0) begin
          $display("%0t unexpected transaction: expected none, actual log=%h wrapped=%b",
                   $time, m_axis_tdata, m_axis_tuser);
          fail_count++;
        end else begin
          want = log_expect_q.pop_front();
          if (m_axis_tdata !== want.log_value) begin
            $display("%0t log_value mismatch: expected %h, actual %h",
                     $time, want.log_value, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tuser !== want.wrapped) begin
            $display("%0t wrapped mismatch: expected %b, actual %b",
                     $time, want.wrapped, m_axis_tuser);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) frac_setting = cfg_data;
      if (s_axis_tvalid && s_axis_tready)
        log_expect_q.push_back(predict_log2(s_axis_tdata, frac_setting));
    end
  end

  // all tasks start and end at a falling edge
  task automatic send_operand(input logic [X_W-1:0] x);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= x;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (log_expect_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_frac_bits(input logic [FRAC_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int src_pct, input int sink_pct, input int hold);
    @(posedge clk);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    sink_hold_cycles = hold;
    @(negedge clk);
  endtask

  task automatic test_default_format();
    send_operand(16'h0000);
    send_operand(16'h0001);
    send_operand(16'h1000);
    send_operand(16'h2000);
    send_operand(16'h0FFF);
    send_operand(16'hFFFF);
  endtask

  // below one clamps to 1, above DATA_WIDTH-2 clamps to DATA_WIDTH-2
  task automatic test_frac_clamping();
    logic [FRAC_W-1:0] setting [4] = '{4'd0, 4'd1, 4'd14, 4'd15};
    foreach (setting[i]) begin
      write_frac_bits(setting[i]);
      send_operand(16'h0001);
      send_operand(16'h0003);
      send_operand(16'h8000);
      send_operand(16'hFFFF);
    end
  endtask

  task automatic test_pressure();
    write_frac_bits(4'd12);
    set_idling(0, 0, 400);
    repeat (80) send_operand(pick_operand(frac_setting));
    drain_results();
    @(negedge clk);
    repeat (40) send_operand(pick_operand(frac_setting));
    drain_results();
  endtask

  task automatic test_random_phase(input int src_pct, input int sink_pct);
    logic [FRAC_W-1:0] value;
    set_idling(src_pct, sink_pct, 0);
    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 0) value = 4'd0;
      else if (seg == 1) value = 4'd15;
      else value = FRAC_W'($urandom_range(2 ** FRAC_W - 1));
      write_frac_bits(value);
      repeat (110) send_operand(pick_operand(value));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_default_format();
    test_frac_clamping();
    test_pressure();
    test_random_phase(23, 74);
    test_random_phase(74, 23);
    test_random_phase(0, 0);
    drain_results();
    repeat (LATENCY + 4) @(negedge clk);
    if (fail_count == 0 && log_expect_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (log_expect_q.size() != 0)
        $display("%0t %0d expected transactions never arrived", $time, log_expect_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
